[src/cto_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cto_pkg;

  localparam int CAP_COUNT = 64;
  localparam int ID_W      = 6;
  localparam int OWNER_W   = 32;
  localparam int FUNC_W    = 2;

  localparam logic [ID_W-1:0] CAP_NONE = '0;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CREATE = 2'd0,
    FUNC_REVOKE = 2'd1,
    FUNC_YIELD  = 2'd2
  } func_t;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture request, issue owner read
    logic exec;   // decide, update table, register result
  } cto_cmd_t;

endpackage

`default_nettype wire

[src/capability_table_ownership.sv]
// Capability slot table with one active capability. A request is taken on
// a clock edge with start high and busy low; busy is then high for one
// cycle while the request is decided, and the result appears on the out_
// ports for exactly one cycle, marked by out_valid, in the cycle after
// busy falls. A request therefore takes two cycles from acceptance to the
// edge that takes its result, and a new request may be taken in the same
// cycle that the previous result is shown, giving one request every two
// cycles. The figure is set by the owner table's registered read port: the
// owner of the named slot is read on the accepting edge and compared in the
// next cycle, and the decision is then registered onto the out_ ports. The
// result cannot be held off, so it must be captured in its strobe cycle.
// No clearing pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module capability_table_ownership (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [cto_pkg::FUNC_W-1:0]   in_func,
  input  wire logic [cto_pkg::ID_W-1:0]     in_cap_id,
  input  wire logic [cto_pkg::ID_W-1:0]     in_target_cap,
  input  wire logic [cto_pkg::OWNER_W-1:0]  in_owner_id,
  output logic                              out_valid,
  output logic                              out_status,
  output logic [cto_pkg::ID_W-1:0]          out_active_cap,
  output logic                              out_invariant_ok
);
  import cto_pkg::*;

  cto_cmd_t cmd;

  cto_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  cto_datapath u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .in_func          (in_func),
    .in_cap_id        (in_cap_id),
    .in_target_cap    (in_target_cap),
    .in_owner_id      (in_owner_id),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_active_cap   (out_active_cap),
    .out_invariant_ok (out_invariant_ok)
  );

endmodule

`default_nettype wire

[src/cto_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module cto_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  output cto_pkg::cto_cmd_t      cmd
);
  import cto_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy     = (state_r == S_EXEC);
  assign cmd.load = (state_r == S_IDLE) && start;
  assign cmd.exec = (state_r == S_EXEC);

endmodule

`default_nettype wire

[src/cto_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module cto_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire cto_pkg::cto_cmd_t            cmd,
  input  wire logic [cto_pkg::FUNC_W-1:0]   in_func,
  input  wire logic [cto_pkg::ID_W-1:0]     in_cap_id,
  input  wire logic [cto_pkg::ID_W-1:0]     in_target_cap,
  input  wire logic [cto_pkg::OWNER_W-1:0]  in_owner_id,
  output logic                              out_valid,
  output logic                              out_status,
  output logic [cto_pkg::ID_W-1:0]          out_active_cap,
  output logic                              out_invariant_ok
);
  import cto_pkg::*;

  // owner store, undefined until a create writes it
  logic [OWNER_W-1:0] owner_mem [CAP_COUNT];

  logic [CAP_COUNT-1:0] valid_r;
  logic [CAP_COUNT-1:0] valid_nxt;
  logic [ID_W-1:0]      active_r;
  logic [ID_W-1:0]      active_nxt;

  logic [FUNC_W-1:0]    func_r;
  logic [ID_W-1:0]      cap_r;
  logic [ID_W-1:0]      tgt_r;
  logic [OWNER_W-1:0]   who_r;
  logic [OWNER_W-1:0]   owner_rd_r;

  logic                 out_valid_r;
  logic                 out_status_r;
  logic [ID_W-1:0]      out_active_r;
  logic                 out_inv_r;

  logic src_live;
  logic dst_live;
  logic own_match;
  logic ok;
  logic mem_we;

  assign src_live  = valid_r[cap_r];
  assign dst_live  = valid_r[tgt_r];
  assign own_match = (owner_rd_r == who_r);

  always_comb begin
    ok         = 1'b0;
    mem_we     = 1'b0;
    valid_nxt  = valid_r;
    active_nxt = active_r;
    case (func_r)
      FUNC_CREATE: begin
        if (!src_live) begin
          ok             = 1'b1;
          mem_we         = 1'b1;
          valid_nxt[cap_r] = 1'b1;
        end
      end
      FUNC_REVOKE: begin
        if (src_live && own_match) begin
          ok               = 1'b1;
          valid_nxt[cap_r] = 1'b0;
          if (active_r == cap_r) active_nxt = CAP_NONE;
        end
      end
      FUNC_YIELD: begin
        if (src_live && dst_live && own_match && (active_r == cap_r)) begin
          ok         = 1'b1;
          active_nxt = tgt_r;
        end
      end
      default: ok = 1'b0;
    endcase
  end

  // owner read is issued on the accepting edge, so it is ready for the decision
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r     <= in_func;
      cap_r      <= in_cap_id;
      tgt_r      <= in_target_cap;
      who_r      <= in_owner_id;
      owner_rd_r <= owner_mem[in_cap_id];
    end
    if (cmd.exec && mem_we) begin
      owner_mem[cap_r] <= who_r;
    end
    if (cmd.exec) begin
      out_status_r <= !ok;
      out_active_r <= active_nxt;
      out_inv_r    <= (active_nxt == CAP_NONE) || valid_nxt[active_nxt];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      active_r    <= CAP_NONE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.exec;
      if (cmd.exec) begin
        valid_r  <= valid_nxt;
        active_r <= active_nxt;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_active_cap   = out_active_r;
  assign out_invariant_ok = out_inv_r;

endmodule

`default_nettype wire
